/* hw/rtl/xorshift64star_bounded_rng_macros.svh */
// Assertion macros shared by the generator RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef XORSHIFT64STAR_BOUNDED_RNG_MACROS_SVH
`define XORSHIFT64STAR_BOUNDED_RNG_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define XSR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xsr assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define XSR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xsr assertion failed");

`endif

/* hw/rtl/xsr_pkg.sv */
// Package for the bounded xorshift64* generator: widths, request codes,
// generator constants and the microcode program of the sequencer.
// Depends on nothing; used by the channel interfaces and the top level.
package xsr_pkg;

	localparam int unsigned STATE_W = 64;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned KIND_W  = 2;

	typedef logic [STATE_W-1:0] state_t;
	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [KIND_W-1:0]  kind_t;

	// Request kinds.
	localparam kind_t KIND_WORD32  = 2'd0;
	localparam kind_t KIND_WORD64  = 2'd1;
	localparam kind_t KIND_BOUNDED = 2'd2;
	localparam kind_t KIND_UNUSED  = 2'd3;

	// Generator constants.
	localparam state_t MULT_CONST  = 64'd2685821657736338717;
	localparam state_t GOLDEN_SEED = 64'h9e3779b97f4a7c15;
	localparam int unsigned SHIFT_A = 12;
	localparam int unsigned SHIFT_B = 25;
	localparam int unsigned SHIFT_C = 27;

	// Divider iteration counter covers one step per dividend bit.
	localparam int unsigned DIV_CNT_W = $clog2(WORD_W);
	typedef logic [DIV_CNT_W-1:0] div_cnt_t;

	// Microcode program counter.
	localparam int unsigned PC_W = 5;
	typedef logic [PC_W-1:0] pc_t;

	// Datapath operations selected by one control word.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_SHIFT,
		OP_MUL_LL,
		OP_MUL_HL,
		OP_MUL_LH,
		OP_SAVE_HI,
		OP_DIV_LIM,
		OP_DIV_VAL,
		OP_DIV_STEP,
		OP_SAVE_LIM,
		OP_RES_ZERO,
		OP_RES_32,
		OP_RES_64,
		OP_RES_REM,
		OP_EMIT
	} op_t;

	// Jump conditions; a false condition falls through to the next step unless done is set.
	typedef enum logic [3:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_REQ,
		COND_KIND0,
		COND_KIND2,
		COND_KIND3,
		COND_BZERO,
		COND_DIV_MORE,
		COND_BELOW_LIM,
		COND_RSP_FULL
	} cond_t;

	// One control word: operation, jump condition and target, and a flag that
	// sends the sequencer back to the idle step when the jump is not taken.
	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
		logic  done;
	} uop_t;

	// Program addresses.
	localparam pc_t P_IDLE    = 5'd0;
	localparam pc_t P_DISP0   = 5'd1;
	localparam pc_t P_DISP1   = 5'd2;
	localparam pc_t P_A_SHIFT = 5'd3;
	localparam pc_t P_A_LL    = 5'd4;
	localparam pc_t P_A_HL    = 5'd5;
	localparam pc_t P_A_LH    = 5'd6;
	localparam pc_t P_HI      = 5'd7;
	localparam pc_t P_B_SHIFT = 5'd8;
	localparam pc_t P_B_LL    = 5'd9;
	localparam pc_t P_B_HL    = 5'd10;
	localparam pc_t P_B_LH    = 5'd11;
	localparam pc_t P_RES64   = 5'd12;
	localparam pc_t P_RES32   = 5'd13;
	localparam pc_t P_ZERO    = 5'd14;
	localparam pc_t P_BND     = 5'd15;
	localparam pc_t P_LIM_DIV = 5'd16;
	localparam pc_t P_LIM     = 5'd17;
	localparam pc_t P_C_SHIFT = 5'd18;
	localparam pc_t P_C_LL    = 5'd19;
	localparam pc_t P_C_HL    = 5'd20;
	localparam pc_t P_C_LH    = 5'd21;
	localparam pc_t P_CHECK   = 5'd22;
	localparam pc_t P_REM_DIV = 5'd23;
	localparam pc_t P_RESREM  = 5'd24;
	localparam pc_t P_EMIT    = 5'd25;

	function automatic uop_t uop(op_t op, cond_t cond, pc_t target, logic done);
		uop_t w;
		w.op     = op;
		w.cond   = cond;
		w.target = target;
		w.done   = done;
		return w;
	endfunction

	// The microcode program.
	function automatic uop_t ucode_rom(pc_t pc);
		uop_t w;
		unique case (pc)
			P_IDLE:    w = uop(OP_ACCEPT,   COND_NO_REQ,    P_IDLE,    1'b0);
			P_DISP0:   w = uop(OP_NOP,      COND_KIND3,     P_ZERO,    1'b0);
			P_DISP1:   w = uop(OP_NOP,      COND_KIND2,     P_BND,     1'b0);
			P_A_SHIFT: w = uop(OP_SHIFT,    COND_NEVER,     P_IDLE,    1'b0);
			P_A_LL:    w = uop(OP_MUL_LL,   COND_NEVER,     P_IDLE,    1'b0);
			P_A_HL:    w = uop(OP_MUL_HL,   COND_NEVER,     P_IDLE,    1'b0);
			P_A_LH:    w = uop(OP_MUL_LH,   COND_KIND0,     P_RES32,   1'b0);
			P_HI:      w = uop(OP_SAVE_HI,  COND_NEVER,     P_IDLE,    1'b0);
			P_B_SHIFT: w = uop(OP_SHIFT,    COND_NEVER,     P_IDLE,    1'b0);
			P_B_LL:    w = uop(OP_MUL_LL,   COND_NEVER,     P_IDLE,    1'b0);
			P_B_HL:    w = uop(OP_MUL_HL,   COND_NEVER,     P_IDLE,    1'b0);
			P_B_LH:    w = uop(OP_MUL_LH,   COND_NEVER,     P_IDLE,    1'b0);
			P_RES64:   w = uop(OP_RES_64,   COND_ALWAYS,    P_EMIT,    1'b0);
			P_RES32:   w = uop(OP_RES_32,   COND_ALWAYS,    P_EMIT,    1'b0);
			P_ZERO:    w = uop(OP_RES_ZERO, COND_ALWAYS,    P_EMIT,    1'b0);
			P_BND:     w = uop(OP_DIV_LIM,  COND_BZERO,     P_ZERO,    1'b0);
			P_LIM_DIV: w = uop(OP_DIV_STEP, COND_DIV_MORE,  P_LIM_DIV, 1'b0);
			P_LIM:     w = uop(OP_SAVE_LIM, COND_NEVER,     P_IDLE,    1'b0);
			P_C_SHIFT: w = uop(OP_SHIFT,    COND_NEVER,     P_IDLE,    1'b0);
			P_C_LL:    w = uop(OP_MUL_LL,   COND_NEVER,     P_IDLE,    1'b0);
			P_C_HL:    w = uop(OP_MUL_HL,   COND_NEVER,     P_IDLE,    1'b0);
			P_C_LH:    w = uop(OP_MUL_LH,   COND_NEVER,     P_IDLE,    1'b0);
			P_CHECK:   w = uop(OP_DIV_VAL,  COND_BELOW_LIM, P_C_SHIFT, 1'b0);
			P_REM_DIV: w = uop(OP_DIV_STEP, COND_DIV_MORE,  P_REM_DIV, 1'b0);
			P_RESREM:  w = uop(OP_RES_REM,  COND_NEVER,     P_IDLE,    1'b0);
			P_EMIT:    w = uop(OP_EMIT,     COND_RSP_FULL,  P_EMIT,    1'b1);
			default:   w = uop(OP_NOP,      COND_ALWAYS,    P_IDLE,    1'b0);
		endcase
		return w;
	endfunction

endpackage

/* hw/rtl/xsr_channels.sv */
// Valid/ready channel interfaces of the generator: request, response and
// seed configuration write. Depends on xsr_pkg for the payload types.

interface xsr_req_if;
	logic          valid;
	logic          ready;
	xsr_pkg::kind_t kind;
	xsr_pkg::word_t bound;

	modport source (output valid, output kind, output bound, input ready);
	modport sink   (input valid, input kind, input bound, output ready);
endinterface

interface xsr_rsp_if;
	logic            valid;
	logic            ready;
	xsr_pkg::state_t value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface xsr_cfg_if;
	logic            valid;
	logic            ready;
	xsr_pkg::state_t seed_value;

	modport source (output valid, output seed_value, input ready);
	modport sink   (input valid, input seed_value, output ready);
endinterface

/* hw/rtl/xorshift64star_bounded_rng.sv */
// One request at a time; the next is taken in the cycle after the response is loaded,
// while that response may still wait. The two 32-step remainder runs set the bounded time.
// Reset clears the generator state (unseeded), the seed register, the response valid and the sequencer.
// Top level of the bounded xorshift64* generator; depends on xsr_pkg, xsr_channels and macros.
`include "xorshift64star_bounded_rng_macros.svh"

module xorshift64star_bounded_rng (
	input  logic clk,
	input  logic arst_n,
	xsr_req_if.sink   req,
	xsr_rsp_if.source rsp,
	xsr_cfg_if.sink   cfg
);
	import xsr_pkg::*;

	// Sequencer and control state.
	pc_t    pc_q;
	uop_t   uw;
	logic   jump;
	pc_t    pc_next;
	logic   rsp_valid_q;
	logic   rsp_full;
	state_t state_q;
	state_t seed_q;

	// Datapath registers.
	kind_t    kind_q;
	word_t    bound_q;
	word_t    acc_q;
	word_t    hi_q;
	word_t    lim_q;
	word_t    rem_q;
	word_t    dvd_q;
	div_cnt_t div_cnt_q;
	state_t   res_q;
	state_t   rsp_value_q;

	// Datapath logic.
	state_t      x_src;
	state_t      x_sh1;
	state_t      x_sh2;
	state_t      x_sh3;
	word_t       mul_a;
	word_t       mul_b;
	state_t      prod;
	logic [32:0] div_t;
	logic [32:0] div_d;
	word_t       rem_next;

	assign uw = ucode_rom(pc_q);

	// Handshakes: requests only in the idle step, seed writes at any time.
	assign req.ready = (uw.op == OP_ACCEPT);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.value = rsp_value_q;
	assign rsp_full  = rsp_valid_q && !rsp.ready;

	// Xorshift step, seeding an empty state first.
	always_comb begin
		if (state_q == '0) begin
			x_src = (seed_q != '0) ? seed_q : GOLDEN_SEED;
		end else begin
			x_src = state_q;
		end
		x_sh1 = x_src ^ (x_src >> SHIFT_A);
		x_sh2 = x_sh1 ^ (x_sh1 << SHIFT_B);
		x_sh3 = x_sh2 ^ (x_sh2 >> SHIFT_C);
	end

	// One shared 32x32 multiplier forms the upper half of the low 64 product bits
	// over three steps: low*low high half, then two cross products' low halves.
	always_comb begin
		unique case (uw.op)
			OP_MUL_LL: begin
				mul_a = state_q[WORD_W-1:0];
				mul_b = MULT_CONST[WORD_W-1:0];
			end
			OP_MUL_HL: begin
				mul_a = state_q[STATE_W-1:WORD_W];
				mul_b = MULT_CONST[WORD_W-1:0];
			end
			default: begin
				mul_a = state_q[WORD_W-1:0];
				mul_b = MULT_CONST[STATE_W-1:WORD_W];
			end
		endcase
		prod = {32'b0, mul_a} * {32'b0, mul_b};
	end

	// Restoring remainder step: one dividend bit per cycle.
	always_comb begin
		div_t    = {rem_q, dvd_q[WORD_W-1]};
		div_d    = div_t - {1'b0, bound_q};
		rem_next = div_d[32] ? div_t[WORD_W-1:0] : div_d[WORD_W-1:0];
	end

	// Jump condition and next step.
	always_comb begin
		unique case (uw.cond)
			COND_NEVER:     jump = 1'b0;
			COND_ALWAYS:    jump = 1'b1;
			COND_NO_REQ:    jump = !req.valid;
			COND_KIND0:     jump = (kind_q == KIND_WORD32);
			COND_KIND2:     jump = (kind_q == KIND_BOUNDED);
			COND_KIND3:     jump = (kind_q == KIND_UNUSED);
			COND_BZERO:     jump = (bound_q == '0);
			COND_DIV_MORE:  jump = (div_cnt_q != '0);
			COND_BELOW_LIM: jump = (acc_q < lim_q);
			COND_RSP_FULL:  jump = rsp_full;
			default:        jump = 1'b0;
		endcase
		if (jump) begin
			pc_next = uw.target;
		end else if (uw.done) begin
			pc_next = P_IDLE;
		end else begin
			pc_next = pc_q + 5'd1;
		end
	end

	// Sequencer, generator state, seed register and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= P_IDLE;
			state_q     <= '0;
			seed_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			if (cfg.valid && cfg.ready) begin
				seed_q <= cfg.seed_value;
			end
			if (uw.op == OP_SHIFT) begin
				state_q <= x_sh3;
			end
			if (uw.op == OP_EMIT && !rsp_full) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers driven by the current control word.
	always_ff @(posedge clk) begin
		case (uw.op)
			OP_ACCEPT: begin
				kind_q  <= req.kind;
				bound_q <= req.bound;
			end
			OP_MUL_LL:   acc_q <= prod[STATE_W-1:WORD_W];
			OP_MUL_HL,
			OP_MUL_LH:   acc_q <= acc_q + prod[WORD_W-1:0];
			OP_SAVE_HI:  hi_q  <= acc_q;
			OP_DIV_LIM: begin
				rem_q     <= '0;
				dvd_q     <= ~bound_q + 32'd1;
				div_cnt_q <= '1;
			end
			OP_DIV_VAL: begin
				rem_q     <= '0;
				dvd_q     <= acc_q;
				div_cnt_q <= '1;
			end
			OP_DIV_STEP: begin
				rem_q     <= rem_next;
				dvd_q     <= dvd_q << 1;
				div_cnt_q <= div_cnt_q - div_cnt_t'(1);
			end
			OP_SAVE_LIM: lim_q <= rem_q;
			OP_RES_ZERO: res_q <= '0;
			OP_RES_32:   res_q <= {32'b0, acc_q};
			OP_RES_64:   res_q <= {hi_q, acc_q};
			OP_RES_REM:  res_q <= {32'b0, rem_q};
			OP_EMIT: begin
				if (!rsp_full) begin
					rsp_value_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	// An accepted request always starts at the dispatch step.
	`XSR_ASSERT_NEXT(a_accept_dispatch, req.valid && req.ready, pc_q == P_DISP0)
	// A generator step never leaves the state at zero.
	`XSR_ASSERT_NEXT(a_state_nonzero, uw.op == OP_SHIFT, state_q != '0)
	// A finished remainder is below the bound.
	`XSR_ASSERT_NOW(a_rem_below, uw.op == OP_RES_REM, rem_q < bound_q)
	// A response loaded by the emit step is offered in the next cycle.
	`XSR_ASSERT_NEXT(a_emit_valid, uw.op == OP_EMIT && !rsp_full, rsp.valid)

endmodule

/* tb/xorshift64star_bounded_rng_test.sv */
// Self-checking testbench for the bounded xorshift64* generator top level.
// Depends on xsr_pkg, the channel interfaces in xsr_channels.sv and the RTL.
module xorshift64star_bounded_rng_test;
	timeunit 1ns;
	timeprecision 1ps;

	import xsr_pkg::*;

	localparam int RANDOM_REQUESTS = 800;
	localparam int RANDOM_PHASES   = 4;
	localparam int CYCLE_LIMIT     = 600000;
	localparam int DRAIN_CYCLES    = 100;
	localparam int MAX_REPORTS     = 10;

	logic clk = 1'b0;
	logic arst_n;

	xsr_req_if req_ch();
	xsr_rsp_if rsp_ch();
	xsr_cfg_if cfg_ch();

	xorshift64star_bounded_rng DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Mirror of the generator: seed register and 64-bit state.
	state_t seed_mirror;
	state_t gen_state;

	// Values still owed by the block, oldest first.
	state_t pending_values[$];

	int  mismatch_count;
	int  stray_count;
	int  cycle_count;
	int  checked_count;
	int  kind_count[4];
	int  rejected_draws;
	int  seed_writes;
	bit  calm;

	// Free-running clock.
	always #5ns clk = ~clk;

	// Cycle limit guards against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d values still owed",
				cycle_count, pending_values.size());
			$display("[xorshift64star_bounded_rng] ERROR");
			$finish;
		end
	end

	// Idle cycles before the next request or result; none in calm phases.
	function automatic int pick_gap();
		if (calm)
			return 0;
		case ($urandom_range(0, 3))
			0, 1: return 0;
			2: return $urandom_range(1, 3);
			default: return $urandom_range(4, 18);
		endcase
	endfunction

	// One xorshift64* step: seeds lazily, advances the state, returns the high word.
	function automatic word_t xorshift_draw();
		state_t x;
		state_t product;
		if (gen_state == '0)
			gen_state = (seed_mirror != '0) ? seed_mirror : GOLDEN_SEED;
		x = gen_state;
		x = x ^ (x >> SHIFT_A);
		x = x ^ (x << SHIFT_B);
		x = x ^ (x >> SHIFT_C);
		gen_state = x;
		product = x * MULT_CONST;
		return product[63:32];
	endfunction

	// Unbiased value below the bound by rejection of the low draws.
	function automatic word_t bounded_draw(word_t bound);
		word_t neg;
		word_t limit;
		word_t r;
		if (bound == '0)
			return '0;
		neg = '0 - bound;
		limit = neg % bound;
		r = xorshift_draw();
		while (r < limit) begin
			rejected_draws++;
			r = xorshift_draw();
		end
		return r % bound;
	endfunction

	// Expected response value of one accepted request.
	function automatic state_t predict_value(kind_t kind, word_t bound);
		word_t hi;
		word_t lo;
		case (kind)
			KIND_WORD32: return {32'd0, xorshift_draw()};
			KIND_WORD64: begin
				hi = xorshift_draw();
				lo = xorshift_draw();
				return {hi, 32'd0} ^ {32'd0, lo};
			end
			KIND_BOUNDED: return {32'd0, bounded_draw(bound)};
			default: return '0;
		endcase
	endfunction

	// Sends one request after a random gap and records its expected value.
	task automatic send_request(input kind_t kind, input word_t bound);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
			req_ch.kind  = kind_t'($urandom);
			req_ch.bound = $urandom;
		end
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.kind  = kind;
		req_ch.bound = bound;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		kind_count[kind]++;
		pending_values.push_back(predict_value(kind, bound));
	endtask

	// Drops valid and waits until every owed value has come back.
	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_values.size() != 0)
			@(posedge clk);
	endtask

	// Writes the seed register while the block is idle.
	task automatic write_seed(input state_t seed);
		@(negedge clk);
		cfg_ch.valid      = 1'b1;
		cfg_ch.seed_value = seed;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		seed_mirror = seed;
		seed_writes++;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Bound with a bias toward the interesting ranges.
	function automatic word_t pick_bound();
		case ($urandom_range(0, 5))
			0: return $urandom_range(1, 16);
			1: return 32'd1 << $urandom_range(0, 31);
			2: return 32'h8000_0000 + $urandom_range(0, 64);
			3: return $urandom;
			4: return 32'hFFFF_FFFF - $urandom_range(0, 8);
			default: return $urandom_range(0, 1000);
		endcase
	endfunction

	function automatic kind_t pick_kind();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 3)
			return KIND_WORD32;
		else if (roll < 5)
			return KIND_WORD64;
		else if (roll < 9)
			return KIND_BOUNDED;
		return KIND_UNUSED;
	endfunction

	// Seed writes before the first draw: requests that never draw keep the
	// state unseeded, so only the last write before a draw decides the seed.
	task automatic test_lazy_seeding();
		write_seed('1);
		send_request(KIND_UNUSED, $urandom);
		send_request(KIND_BOUNDED, '0);
		wait_idle();
		write_seed('0);
		send_request(KIND_BOUNDED, '0);
		wait_idle();
		case ($urandom_range(0, 2))
			0: write_seed('0);
			1: write_seed('1);
			default: write_seed({$urandom, $urandom});
		endcase
		send_request(KIND_UNUSED, '1);
		send_request(KIND_WORD32, '0);
		wait_idle();
	endtask

	// Every request kind with the edge bounds.
	task automatic test_directed_kinds();
		send_request(KIND_WORD32, '1);
		send_request(KIND_WORD64, '0);
		send_request(KIND_WORD64, '1);
		send_request(KIND_BOUNDED, 32'd1);
		send_request(KIND_BOUNDED, 32'd2);
		send_request(KIND_BOUNDED, 32'd3);
		send_request(KIND_BOUNDED, 32'd0);
		send_request(KIND_BOUNDED, 32'hFFFF_FFFF);
		send_request(KIND_BOUNDED, 32'h8000_0000);
		send_request(KIND_BOUNDED, 32'h8000_0001);
		send_request(KIND_BOUNDED, 32'h7FFF_FFFF);
		send_request(KIND_BOUNDED, 32'h5555_5556);
		send_request(KIND_UNUSED, 32'hFFFF_FFFF);
		send_request(KIND_UNUSED, 32'd0);
		send_request(KIND_WORD32, 32'hA5A5_A5A5);
		wait_idle();
	endtask

	// A seed written after seeding must leave the running state alone.
	task automatic test_reseed_ignored();
		write_seed('1);
		send_request(KIND_WORD32, '0);
		send_request(KIND_WORD64, '0);
		wait_idle();
		write_seed('0);
		send_request(KIND_BOUNDED, 32'd10);
		send_request(KIND_WORD32, '0);
		wait_idle();
	endtask

	// Random traffic in phases, alternating calm and stalled handshakes,
	// with a new seed written between phases.
	task automatic test_random_traffic();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			calm = (phase % 2) == 1;
			for (int n = 0; n < RANDOM_REQUESTS / RANDOM_PHASES; n++)
				send_request(pick_kind(), pick_bound());
			wait_idle();
			write_seed({$urandom, $urandom});
		end
		calm = 1'b0;
	endtask

	// Response side: random stalls, each accepted value checked in order.
	initial begin : response_side
		int     stall_left;
		state_t want;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_ch.ready = 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready = 1'b1;
			end
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_values.size() == 0) begin
					stray_count++;
					if (mismatch_count + stray_count <= MAX_REPORTS)
						$display("Unexpected response value %h at cycle %0d",
							rsp_ch.value, cycle_count);
				end else begin
					want = pending_values.pop_front();
					checked_count++;
					if (rsp_ch.value !== want) begin
						mismatch_count++;
						if (mismatch_count + stray_count <= MAX_REPORTS)
							$display("Value mismatch at cycle %0d: expected %h, got %h",
								cycle_count, want, rsp_ch.value);
					end
				end
				stall_left = pick_gap();
			end
		end
	end

	// Stimulus: reset once, then the tests in turn, then the verdict.
	initial begin : stimulus
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.kind       = KIND_WORD32;
		req_ch.bound      = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.seed_value = '0;
		seed_mirror       = '0;
		gen_state         = '0;
		mismatch_count    = 0;
		stray_count       = 0;
		cycle_count       = 0;
		checked_count     = 0;
		rejected_draws    = 0;
		seed_writes       = 0;
		calm              = 1'b0;
		kind_count        = '{default: 0};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_lazy_seeding();
		test_directed_kinds();
		test_reseed_ignored();
		test_random_traffic();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d responses: %0d word32, %0d word64, %0d bounded, %0d unused kind.",
			checked_count, kind_count[KIND_WORD32], kind_count[KIND_WORD64],
			kind_count[KIND_BOUNDED], kind_count[KIND_UNUSED]);
		$display("Seed writes: %0d, rejected bounded draws: %0d, mismatches: %0d, stray: %0d.",
			seed_writes, rejected_draws, mismatch_count, stray_count);
		if (mismatch_count == 0 && stray_count == 0 && pending_values.size() == 0) begin
			$display("[xorshift64star_bounded_rng] OK");
		end else begin
			$display("%0d values never arrived", pending_values.size());
			$display("[xorshift64star_bounded_rng] ERROR");
		end
		$finish;
	end

endmodule
